[hw/rtl/capsule_sphere_collision_macros.svh]
// Assertion macros for the capsule and sphere collision block.
// Included by the top level; the macros expand to nothing for synthesis.
`ifndef CAPSULE_SPHERE_COLLISION_MACROS_SVH
`define CAPSULE_SPHERE_COLLISION_MACROS_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capsule_sphere_collision: implication check failed");
`define CSC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capsule_sphere_collision: next cycle check failed");
`else
`define CSC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/csc_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, types and codes of the capsule and sphere collision block.
// Depends on nothing; every other file but the macros header imports it.
package csc_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = 30;
  localparam int RSUM_W    = RAD_W + 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int LEN_W     = 2 * COORD_W + 2;
  localparam int DOT_W     = LEN_W + 1;
  localparam int HALF_W    = (LEN_W + 1) / 2;
  localparam int PP_W      = MAG_W + HALF_W;
  localparam int E_W       = DIFF_W + 1;
  localparam int ESQ_W     = 2 * E_W - 2;
  localparam int DSQ_W     = ESQ_W + 2;
  localparam int RR_W      = 2 * RSUM_W;
  localparam int DIR_W     = FRAC_BITS + 2;
  localparam int DEPTH_W   = RSUM_W;
  localparam int DIR_SHIFT = 2 * FRAC_BITS + 2;

  localparam int DIV_NUM_W = 100;
  localparam int DIV_DEN_W = LEN_W + 1;
  localparam int DIV_Q_W   = 35;

  localparam int SQ_IN_W   = RR_W;
  localparam int SQ_OUT_W  = RR_W / 2;
  localparam int SQ_REM_W  = SQ_OUT_W + 1;

  localparam int FRONT_LAT = 5;
  localparam int BACK_LAT  = 2 * DIV_Q_W + SQ_OUT_W + 5;

  localparam int QD     = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    CL_START = 2'd0,
    CL_END   = 2'd1,
    CL_MID   = 2'd2
  } clamp_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0]    d;
    logic [2:0][DIFF_W-1:0]    v;
    logic [LEN_W-1:0]          len;
    logic [2:0][DIV_NUM_W-1:0] num;
    clamp_t                    cl;
    logic [RSUM_W-1:0]         rsum;
  } qent_t;

endpackage

[hw/rtl/csc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the query and result beats.
// Depends on csc_pkg for the field widths.
interface csc_in_if import csc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cap_a_x;
  logic signed [COORD_W-1:0] cap_a_y;
  logic signed [COORD_W-1:0] cap_a_z;
  logic signed [COORD_W-1:0] cap_b_x;
  logic signed [COORD_W-1:0] cap_b_y;
  logic signed [COORD_W-1:0] cap_b_z;
  logic [RAD_W-1:0]          cap_radius;
  logic signed [COORD_W-1:0] sphere_x;
  logic signed [COORD_W-1:0] sphere_y;
  logic signed [COORD_W-1:0] sphere_z;
  logic [RAD_W-1:0]          sphere_radius;

  modport source (output valid, cap_a_x, cap_a_y, cap_a_z, cap_b_x, cap_b_y, cap_b_z,
                  cap_radius, sphere_x, sphere_y, sphere_z, sphere_radius, input ready);
  modport sink (input valid, cap_a_x, cap_a_y, cap_a_z, cap_b_x, cap_b_y, cap_b_z,
                cap_radius, sphere_x, sphere_y, sphere_z, sphere_radius, output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic [DEPTH_W-1:0]      depth;

  modport source (output valid, hit, dir_x, dir_y, dir_z, depth, input ready);
  modport sink (input valid, hit, dir_x, dir_y, dir_z, depth, output ready);
endinterface

[hw/rtl/csc_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, advancing on en.
// Depends on csc_pkg for its fixed widths.
module csc_div import csc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo
);

  logic [DIV_DEN_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   low_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W];
  logic [DIV_DEN_W:0]   st [DIV_Q_W];

  function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] r,
                                                  input logic [DIV_DEN_W-1:0] d,
                                                  input logic b);
    logic [DIV_DEN_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, DIV_DEN_W'(t - {1'b0, d})};
    end
    return {1'b0, t[DIV_DEN_W-1:0]};
  endfunction

  always_comb begin
    st[0] = div_step(DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]), den, num[DIV_Q_W-1]);
    for (int s = 1; s < DIV_Q_W; s++) begin
      st[s] = div_step(rem_q[s-1], den_q[s-1], low_q[s-1][DIV_Q_W-1-s]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= st[0][DIV_DEN_W-1:0];
      den_q[0] <= den;
      low_q[0] <= num[DIV_Q_W-1:0];
      quo_q[0] <= DIV_Q_W'(st[0][DIV_DEN_W]) << (DIV_Q_W - 1);
      for (int s = 1; s < DIV_Q_W; s++) begin
        rem_q[s] <= st[s][DIV_DEN_W-1:0];
        den_q[s] <= den_q[s-1];
        low_q[s] <= low_q[s-1];
        quo_q[s] <= quo_q[s-1] | (DIV_Q_W'(st[s][DIV_DEN_W]) << (DIV_Q_W - 1 - s));
      end
    end
  end

  assign quo = quo_q[DIV_Q_W-1];

endmodule

[hw/rtl/csc_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with the remainder.
// Depends on csc_pkg for its fixed widths.
module csc_sqrt import csc_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  arg,
  output logic [SQ_OUT_W-1:0] root,
  output logic [SQ_REM_W-1:0] rem
);

  logic [SQ_REM_W-1:0] rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];
  logic [SQ_IN_W-1:0]  arg_q  [SQ_OUT_W];
  logic [SQ_REM_W:0]   st [SQ_OUT_W];

  function automatic logic [SQ_REM_W:0] sq_step(input logic [SQ_REM_W-1:0] r,
                                                input logic [SQ_OUT_W-1:0] q,
                                                input logic [1:0] pair);
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] cand;
    t    = {r, pair};
    cand = (SQ_REM_W + 2)'({q, 2'b01});
    if (t >= cand) begin
      return {1'b1, SQ_REM_W'(t - cand)};
    end
    return {1'b0, t[SQ_REM_W-1:0]};
  endfunction

  always_comb begin
    st[0] = sq_step('0, '0, arg[2*(SQ_OUT_W-1) +: 2]);
    for (int s = 1; s < SQ_OUT_W; s++) begin
      st[s] = sq_step(rem_q[s-1], root_q[s-1], arg_q[s-1][2*(SQ_OUT_W-1-s) +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= st[0][SQ_REM_W-1:0];
      root_q[0] <= SQ_OUT_W'(st[0][SQ_REM_W]);
      arg_q[0]  <= arg;
      for (int s = 1; s < SQ_OUT_W; s++) begin
        rem_q[s]  <= st[s][SQ_REM_W-1:0];
        root_q[s] <= {root_q[s-1][SQ_OUT_W-2:0], st[s][SQ_REM_W]};
        arg_q[s]  <= arg_q[s-1];
      end
    end
  end

  assign root = root_q[SQ_OUT_W-1];
  assign rem  = rem_q[SQ_OUT_W-1];

endmodule

[hw/rtl/csc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts query beats, forms the segment products and classifies
// the projection, then pushes a prepared entry. Depends on csc_pkg, csc_if.
module csc_front import csc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  csc_in_if.sink  query,
  output logic    push,
  output qent_t   push_ent
);

  logic [FRONT_LAT-1:0] vld;

  logic [2:0][COORD_W-1:0] ca, cb, sp;
  logic [2:0][DIFF_W-1:0]  d_n, v_n;
  logic [2:0][DIFF_W-1:0]  f1_d, f1_v, f2_d, f2_v, f3_d, f3_v, f4_d, f4_v;
  logic [RSUM_W-1:0]       f1_rs, f2_rs, f3_rs, f4_rs;
  logic [2:0][PROD_W-1:0]  dd_n, dv_n, f2_dd, f2_dv;
  logic [LEN_W-1:0]        len_n, f3_len, f4_len;
  logic [DOT_W-1:0]        dot_n, f3_dot;
  clamp_t                  cl_n, f4_cl;
  logic [2:0][MAG_W-1:0]   mag;
  logic [2:0][PP_W-1:0]    pl_n, ph_n, f4_pl, f4_ph;
  logic [2:0][DIV_NUM_W-1:0] num_n;

  assign ca = {query.cap_a_z, query.cap_a_y, query.cap_a_x};
  assign cb = {query.cap_b_z, query.cap_b_y, query.cap_b_x};
  assign sp = {query.sphere_z, query.sphere_y, query.sphere_x};

  assign query.ready = en;
  assign push        = en && vld[FRONT_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_n[i]  = {cb[i][COORD_W-1], cb[i]} - {ca[i][COORD_W-1], ca[i]};
      v_n[i]  = {sp[i][COORD_W-1], sp[i]} - {ca[i][COORD_W-1], ca[i]};
      dd_n[i] = PROD_W'($signed(f1_d[i]) * $signed(f1_d[i]));
      dv_n[i] = PROD_W'($signed(f1_d[i]) * $signed(f1_v[i]));
      mag[i]  = f3_d[i][DIFF_W-1] ? MAG_W'(-f3_d[i]) : MAG_W'(f3_d[i]);
      pl_n[i] = PP_W'(mag[i]) * PP_W'(f3_dot[HALF_W-1:0]);
      ph_n[i] = PP_W'(mag[i]) * PP_W'(f3_dot[LEN_W-1:HALF_W]);
      num_n[i] = (((DIV_NUM_W'(f4_ph[i]) << HALF_W) + DIV_NUM_W'(f4_pl[i])) << 1)
                 + DIV_NUM_W'(f4_len);
    end
    len_n = LEN_W'(f2_dd[0]) + LEN_W'(f2_dd[1]) + LEN_W'(f2_dd[2]);
    dot_n = DOT_W'($signed(f2_dv[0])) + DOT_W'($signed(f2_dv[1]))
            + DOT_W'($signed(f2_dv[2]));
    if (f3_len == '0 || f3_dot[DOT_W-1] || f3_dot == '0) begin
      cl_n = CL_START;
    end else if (f3_dot >= {1'b0, f3_len}) begin
      cl_n = CL_END;
    end else begin
      cl_n = CL_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_LAT-2:0], query.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_d  <= d_n;
      f1_v  <= v_n;
      f1_rs <= RSUM_W'(query.cap_radius) + RSUM_W'(query.sphere_radius);
      f2_d  <= f1_d;
      f2_v  <= f1_v;
      f2_rs <= f1_rs;
      f2_dd <= dd_n;
      f2_dv <= dv_n;
      f3_d  <= f2_d;
      f3_v  <= f2_v;
      f3_rs <= f2_rs;
      f3_len <= len_n;
      f3_dot <= dot_n;
      f4_d  <= f3_d;
      f4_v  <= f3_v;
      f4_rs <= f3_rs;
      f4_len <= f3_len;
      f4_cl <= cl_n;
      f4_pl <= pl_n;
      f4_ph <= ph_n;
      push_ent.d    <= f4_d;
      push_ent.v    <= f4_v;
      push_ent.len  <= f4_len;
      push_ent.num  <= num_n;
      push_ent.cl   <= f4_cl;
      push_ent.rsum <= f4_rs;
    end
  end

endmodule

[hw/rtl/csc_back.sv]
`timescale 1ns / 1ps
// Back end: closest point division, distance, direction and depth, ending in
// the result register. Depends on csc_pkg, csc_if, csc_div and csc_sqrt.
module csc_back import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      ent_valid,
  input  qent_t     ent,
  output logic      pop,
  csc_out_if.source result
);

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d;
    logic [2:0][DIFF_W-1:0] v;
    clamp_t                 cl;
    logic [RSUM_W-1:0]      rsum;
  } sba_t;

  typedef struct packed {
    logic              hit;
    logic              zero;
    logic [2:0]        neg;
    logic [RSUM_W-1:0] rsum;
    logic [RR_W-1:0]   dsq;
  } sbb_t;

  typedef struct packed {
    logic              hit;
    logic              zero;
    logic [2:0]        neg;
    logic [RSUM_W-1:0] rsum;
  } sbc_t;

  logic                en;
  logic [BACK_LAT-1:0] vld;
  qent_t               s0;
  sba_t                sba [DIV_Q_W];
  sbb_t                sbb [DIV_Q_W];
  sbc_t                sbc [SQ_OUT_W];

  logic [2:0][DIV_Q_W-1:0]  rq, dq;
  logic [2:0][DIFF_W-1:0]   off;
  logic [2:0][E_W-1:0]      e_n, s1_e;
  logic [RR_W-1:0]          s1_rr, s2_rr;
  logic [RSUM_W-1:0]        s1_rs, s2_rs, s3_rs;
  logic [2:0][ESQ_W-1:0]    sq_n, s2_sq, s3_sq;
  logic [2:0]               s2_neg, s3_neg;
  logic [DSQ_W-1:0]         dsq_n, s3_dsq;
  logic                     s3_hit, s3_zero;
  logic [SQ_OUT_W-1:0]      droot;
  logic [SQ_REM_W-1:0]      drem;
  logic [2:0][SQ_OUT_W-1:0] vroot;
  logic [2:0][SQ_REM_W-1:0] vrem;
  logic [SQ_REM_W-1:0]      dist_rnd;
  logic [2:0][DIR_W-1:0]    nrm, dir_n;
  logic [DEPTH_W-1:0]       depth_n;

  assign result.valid = vld[BACK_LAT-1];
  assign en           = !result.valid || result.ready;
  assign pop          = en && ent_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_LAT-2:0], pop};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    csc_div u_rdiv (
      .clk (clk),
      .en  (en),
      .num (s0.num[i]),
      .den ({s0.len, 1'b0}),
      .quo (rq[i])
    );
    csc_div u_ddiv (
      .clk (clk),
      .en  (en),
      .num (DIV_NUM_W'({s3_sq[i][RR_W-1:0], {DIR_SHIFT{1'b0}}})),
      .den (DIV_DEN_W'(s3_dsq[RR_W-1:0])),
      .quo (dq[i])
    );
    csc_sqrt u_vsqrt (
      .clk  (clk),
      .en   (en),
      .arg  (SQ_IN_W'(dq[i])),
      .root (vroot[i]),
      .rem  (vrem[i])
    );
  end

  csc_sqrt u_dsqrt (
    .clk  (clk),
    .en   (en),
    .arg  (sbb[DIV_Q_W-1].dsq),
    .root (droot),
    .rem  (drem)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (sba[DIV_Q_W-1].cl)
        CL_START: off[i] = '0;
        CL_END:   off[i] = sba[DIV_Q_W-1].d[i];
        CL_MID: begin
          if (sba[DIV_Q_W-1].d[i][DIFF_W-1]) begin
            off[i] = -{1'b0, rq[i][MAG_W-1:0]};
          end else begin
            off[i] = {1'b0, rq[i][MAG_W-1:0]};
          end
        end
        default:  off[i] = '0;
      endcase
      e_n[i] = {sba[DIV_Q_W-1].v[i][DIFF_W-1], sba[DIV_Q_W-1].v[i]}
               - {off[i][DIFF_W-1], off[i]};
      sq_n[i] = ESQ_W'($signed(s1_e[i]) * $signed(s1_e[i]));
      nrm[i]  = (vroot[i][DIR_W-1:0] + DIR_W'(1)) >> 1;
      dir_n[i] = '0;
      if (sbc[SQ_OUT_W-1].hit && !sbc[SQ_OUT_W-1].zero) begin
        dir_n[i] = sbc[SQ_OUT_W-1].neg[i] ? -nrm[i] : nrm[i];
      end
    end
    dsq_n    = DSQ_W'(s2_sq[0]) + DSQ_W'(s2_sq[1]) + DSQ_W'(s2_sq[2]);
    dist_rnd = SQ_REM_W'(droot) + SQ_REM_W'(drem > SQ_REM_W'(droot));
    depth_n  = '0;
    if (sbc[SQ_OUT_W-1].hit) begin
      depth_n = DEPTH_W'(SQ_REM_W'(sbc[SQ_OUT_W-1].rsum) - dist_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= ent;
      sba[0].d    <= s0.d;
      sba[0].v    <= s0.v;
      sba[0].cl   <= s0.cl;
      sba[0].rsum <= s0.rsum;
      for (int k = 1; k < DIV_Q_W; k++) begin
        sba[k] <= sba[k-1];
      end
      s1_e  <= e_n;
      s1_rr <= RR_W'(sba[DIV_Q_W-1].rsum) * RR_W'(sba[DIV_Q_W-1].rsum);
      s1_rs <= sba[DIV_Q_W-1].rsum;
      s2_sq <= sq_n;
      s2_rr <= s1_rr;
      s2_rs <= s1_rs;
      for (int i = 0; i < 3; i++) begin
        s2_neg[i] <= s1_e[i][E_W-1];
      end
      s3_sq   <= s2_sq;
      s3_neg  <= s2_neg;
      s3_rs   <= s2_rs;
      s3_dsq  <= dsq_n;
      s3_hit  <= dsq_n < DSQ_W'(s2_rr);
      s3_zero <= dsq_n == '0;
      sbb[0].hit  <= s3_hit;
      sbb[0].zero <= s3_zero;
      sbb[0].neg  <= s3_neg;
      sbb[0].rsum <= s3_rs;
      sbb[0].dsq  <= s3_dsq[RR_W-1:0];
      for (int k = 1; k < DIV_Q_W; k++) begin
        sbb[k] <= sbb[k-1];
      end
      sbc[0].hit  <= sbb[DIV_Q_W-1].hit;
      sbc[0].zero <= sbb[DIV_Q_W-1].zero;
      sbc[0].neg  <= sbb[DIV_Q_W-1].neg;
      sbc[0].rsum <= sbb[DIV_Q_W-1].rsum;
      for (int k = 1; k < SQ_OUT_W; k++) begin
        sbc[k] <= sbc[k-1];
      end
      result.hit   <= sbc[SQ_OUT_W-1].hit;
      result.dir_x <= dir_n[0];
      result.dir_y <= dir_n[1];
      result.dir_z <= dir_n[2];
      result.depth <= depth_n;
    end
  end

endmodule

[hw/rtl/capsule_sphere_collision.sv]
`timescale 1ns / 1ps
// Top level of the capsule and sphere collision block: front end, entry queue
// and back end. Depends on csc_pkg, csc_if, csc_front and csc_back.
//
// One query beat is accepted per clock while the queue is not full, and one
// result beat leaves per clock when the result side is ready. A query passes
// through the front end, the four-entry queue and the back end; the back end
// length is set by the two 35-stage dividers and the 31-stage square root
// units in series. The front end keeps accepting until the queue is full.
`include "capsule_sphere_collision_macros.svh"
module capsule_sphere_collision import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  csc_in_if.sink    query,
  csc_out_if.source result
);

  logic              front_en;
  logic              push;
  logic              pop;
  qent_t             push_ent;
  qent_t             qmem [QD];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] q_count;

  assign front_en = q_count != QCNT_W'(QD);

  csc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (front_en),
    .query    (query),
    .push     (push),
    .push_ent (push_ent)
  );

  csc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (q_count != '0),
    .ent       (qmem[rptr]),
    .pop       (pop),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + QCNT_W'(1);
        2'b01:   q_count <= q_count - QCNT_W'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  `CSC_ASSERT_IMP(a_count_range, clk, rst, 1'b1, q_count <= QCNT_W'(QD))
  `CSC_ASSERT_IMP(a_no_push_full, clk, rst, push, q_count != QCNT_W'(QD))
  `CSC_ASSERT_NXT(a_count_grows, clk, rst, push && !pop, q_count == ($past(q_count) + QCNT_W'(1)))
  `CSC_ASSERT_IMP(a_miss_zero, clk, rst, result.valid && !result.hit, result.dir_x == '0 && result.dir_y == '0 && result.dir_z == '0 && result.depth == '0)

endmodule

[sim/csc_collision_checker.sv]
`timescale 1ns / 1ps
// Checker for the capsule and sphere collision block: predicts every result from
// the accepted query beats and compares it with the result beats. Uses csc_pkg, csc_if.
module csc_collision_checker import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  csc_in_if         query,
  csc_out_if        result,
  output int        errors,
  output int        outstanding
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic                hit;
    logic [DIR_W-1:0]    dir_x;
    logic [DIR_W-1:0]    dir_y;
    logic [DIR_W-1:0]    dir_z;
    logic [DEPTH_W-1:0]  depth;
  } contact_t;

  contact_t contacts_due[$];

  function automatic wide_t root_floor(input wide_t a);
    wide_t r, c;
    r = 0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= a) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(input wide_t pa[3], input wide_t pb[3],
                                               input wide_t pp[3], input wide_t rsum);
    wide_t d[3], v[3], e[3], off, len, dot, dsq, dist_rnd, prod, mag, m, s, n;
    logic low_end, high_end;
    contact_t c;
    len = 0;
    dot = 0;
    dsq = 0;
    c = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      d[i] = pb[i] - pa[i];
      v[i] = pp[i] - pa[i];
      len += d[i] * d[i];
      dot += d[i] * v[i];
    end
    low_end = (len == 0) || (dot <= 0);
    high_end = !low_end && (dot >= len);
    for (int i = 0; i < 3; i++) begin
      if (low_end) off = 0;
      else if (high_end) off = d[i];
      else begin
        prod = d[i] * dot;
        mag = (prod < 0) ? -prod : prod;
        off = (2 * mag + len) / (2 * len);
        if (prod < 0) off = -off;
      end
      e[i] = v[i] - off;
      dsq += e[i] * e[i];
    end
    if (dsq >= rsum * rsum) return c;
    dist_rnd = root_floor(dsq);
    if (dsq - dist_rnd * dist_rnd > dist_rnd) dist_rnd += 1;
    c.hit = 1'b1;
    c.depth = DEPTH_W'(rsum - dist_rnd);
    if (dsq != 0) begin
      for (int i = 0; i < 3; i++) begin
        m = ((e[i] < 0) ? -e[i] : e[i]) <<< FRAC_BITS;
        s = root_floor(((m * m) <<< 2) / dsq);
        n = (s + 1) >>> 1;
        if (e[i] < 0) n = -n;
        if (i == 0) c.dir_x = DIR_W'(n);
        else if (i == 1) c.dir_y = DIR_W'(n);
        else c.dir_z = DIR_W'(n);
      end
    end
    return c;
  endfunction

  assign outstanding = contacts_due.size();

  always @(posedge clk) begin
    wide_t pa[3], pb[3], pp[3];
    contact_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (query.valid && query.ready) begin
        pa = '{wide_t'(query.cap_a_x), wide_t'(query.cap_a_y), wide_t'(query.cap_a_z)};
        pb = '{wide_t'(query.cap_b_x), wide_t'(query.cap_b_y), wide_t'(query.cap_b_z)};
        pp = '{wide_t'(query.sphere_x), wide_t'(query.sphere_y), wide_t'(query.sphere_z)};
        contacts_due.push_back(predict_contact(pa, pb, pp,
          wide_t'({1'b0, query.cap_radius}) + wide_t'({1'b0, query.sphere_radius})));
      end
      if (result.valid && result.ready) begin
        if (contacts_due.size() == 0) begin
          $error("result beat with no query outstanding");
          errors <= errors + 1;
        end else begin
          want = contacts_due.pop_front();
          if (result.hit !== want.hit || result.dir_x !== want.dir_x ||
              result.dir_y !== want.dir_y || result.dir_z !== want.dir_z ||
              result.depth !== want.depth) begin
            errors <= errors + 1;
            if (result.hit !== want.hit)
              $error("hit: expected %0d, got %0d", want.hit, result.hit);
            if (result.dir_x !== want.dir_x)
              $error("dir_x: expected %0d, got %0d", $signed(want.dir_x), result.dir_x);
            if (result.dir_y !== want.dir_y)
              $error("dir_y: expected %0d, got %0d", $signed(want.dir_y), result.dir_y);
            if (result.dir_z !== want.dir_z)
              $error("dir_z: expected %0d, got %0d", $signed(want.dir_z), result.dir_z);
            if (result.depth !== want.depth)
              $error("depth: expected %0d, got %0d", want.depth, result.depth);
          end
        end
      end
    end
  end

endmodule

[sim/tb_capsule_sphere_collision.sv]
`timescale 1ns / 1ps
// Testbench top for the capsule and sphere collision block: clock, reset, query
// stimulus, result stalls and verdict. Uses csc_pkg, csc_if and csc_collision_checker.
module tb_capsule_sphere_collision;
  import csc_pkg::*;

  localparam int RANDOM_QUERIES = 1030;
  localparam int CALM_FROM      = 900;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct {
    logic signed [COORD_W-1:0] a[3];
    logic signed [COORD_W-1:0] b[3];
    logic signed [COORD_W-1:0] p[3];
    logic [RAD_W-1:0]          cap_r;
    logic [RAD_W-1:0]          sph_r;
  } shape_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   cycles = 0;
  int   sent = 0;
  logic calm = 1'b0;

  csc_in_if  query();
  csc_out_if result();

  capsule_sphere_collision dut (.clk(clk), .rst(rst), .query(query), .result(result));

  csc_collision_checker checker_i (.clk(clk), .rst(rst), .query(query), .result(result),
                                   .errors(errors), .outstanding(outstanding));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic shape_pair_t uniform_pair();
    shape_pair_t s;
    for (int i = 0; i < 3; i++) begin
      s.a[i] = $urandom;
      s.b[i] = $urandom;
      s.p[i] = $urandom;
    end
    s.cap_r = RAD_W'($urandom);
    s.sph_r = RAD_W'($urandom);
    return s;
  endfunction

  function automatic shape_pair_t nearby_pair(input int kind);
    shape_pair_t s;
    int base, span;
    span = 1 << $urandom_range(4, 22);
    for (int i = 0; i < 3; i++) begin
      base = $urandom;
      s.a[i] = base + jitter(span);
      s.b[i] = (kind == 1) ? s.a[i] : base + jitter(span);
      s.p[i] = base + jitter(span);
    end
    if (kind == 2)
      for (int i = 0; i < 3; i++)
        s.p[i] = s.a[i] + (s.b[i] - s.a[i]) / 2 + jitter(2);
    s.cap_r = RAD_W'($urandom_range(0, span));
    s.sph_r = RAD_W'($urandom_range(0, span));
    return s;
  endfunction

  function automatic shape_pair_t make_pair(input int a0, a1, a2, b0, b1, b2,
                                            p0, p1, p2, int unsigned cr, sr);
    shape_pair_t s;
    s.a = '{a0, a1, a2};
    s.b = '{b0, b1, b2};
    s.p = '{p0, p1, p2};
    s.cap_r = RAD_W'(cr);
    s.sph_r = RAD_W'(sr);
    return s;
  endfunction

  task automatic send_query(input shape_pair_t s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      query.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    query.valid         <= 1'b1;
    query.cap_a_x       <= s.a[0];
    query.cap_a_y       <= s.a[1];
    query.cap_a_z       <= s.a[2];
    query.cap_b_x       <= s.b[0];
    query.cap_b_y       <= s.b[1];
    query.cap_b_z       <= s.b[2];
    query.sphere_x      <= s.p[0];
    query.sphere_y      <= s.p[1];
    query.sphere_z      <= s.p[2];
    query.cap_radius    <= s.cap_r;
    query.sphere_radius <= s.sph_r;
    do @(posedge clk); while (!query.ready);
    sent++;
  endtask

  initial begin
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        result.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    shape_pair_t directed[$];
    int r;
    query.valid <= 1'b0;
    query.cap_a_x <= '0;
    query.cap_a_y <= '0;
    query.cap_a_z <= '0;
    query.cap_b_x <= '0;
    query.cap_b_y <= '0;
    query.cap_b_z <= '0;
    query.sphere_x <= '0;
    query.sphere_y <= '0;
    query.sphere_z <= '0;
    query.cap_radius <= '0;
    query.sphere_radius <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A point capsule, a centre behind A, one beyond B and one inside the segment.
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 65536, 0, 0, 65536, 65536));
    directed.push_back(make_pair(0, 0, 0, 655360, 0, 0, -65536, 1000, 0, 131072, 0));
    directed.push_back(make_pair(0, 0, 0, 655360, 0, 0, 720000, -3000, 77, 65536, 65536));
    directed.push_back(make_pair(0, 0, 0, 655360, 65536, 0, 300001, 70000, -5, 100000, 9));
    directed.push_back(make_pair(5, 7, 9, 5, 7, 9, 5, 7, 9, 3, 4));
    // Spheres that touch exactly and a hit whose rounded depth is zero.
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 70000, 0, 0, 30000, 40000));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, -3, 4, 2, 3));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1));
    directed.push_back(make_pair(-10, 4, 4, 10, 4, 4, 0, 0, 0, 0, 0));
    directed.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 32'h80000000, 32'h80000000, 32'h80000000,
                                 0, 0, 0, 30'h3fffffff, 30'h3fffffff));
    directed.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 30'h3fffffff, 30'h3fffffff));
    directed.push_back(make_pair(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0,
                                 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0,
                                 30'h3fffffff, 0));
    directed.push_back(make_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0,
                                 32'hffffffff, 0, 32'hffffffff, 0, 30'h3fffffff));
    directed.push_back(make_pair(0, 0, 0, 3, 0, 0, 1, 1, 0, 2, 0));
    directed.push_back(make_pair(0, 0, 0, 2, 0, 0, 1, 5, 0, 10, 0));
    foreach (directed[i]) send_query(directed[i]);

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == CALM_FROM) calm = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 3) send_query(uniform_pair());
      else if (r < 6) send_query(nearby_pair(1));
      else if (r < 9) send_query(nearby_pair(2));
      else send_query(nearby_pair(0));
    end
    query.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
